/* hw/rtl/asw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asw_pkg
// shared types and constants for the age-structured sir week stepper
// ----------------------------------------------------------------------------
package asw_pkg;

    localparam int MUL_W  = 64;
    localparam int PROD_W = 128;
    localparam int CFG_IDX_W = 4;

    localparam logic [30:0] Q30_ONE       = 31'h4000_0000;
    localparam logic [31:0] SAT32         = 32'hFFFF_FFFF;
    localparam logic [40:0] MOVE_CAP      = 41'h100_0000_0000;
    localparam logic [2:0]  DAYS_PER_WEEK = 3'd7;

    typedef enum logic [1:0] {
        MODE_LOAD_CONTACT = 2'd0,
        MODE_LOAD_VACC    = 2'd1,
        MODE_START_SEASON = 2'd2,
        MODE_ADVANCE_WEEK = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_R0        = 4'd0,
        REG_RECOVERY  = 4'd1,
        REG_VE_INF    = 4'd2,
        REG_VE_SPREAD = 4'd3,
        REG_VE_ILL    = 4'd4,
        REG_PULSE_DAY = 4'd5,
        REG_INIT_S    = 4'd6,
        REG_INIT_I    = 4'd7
    } cfg_index_t;

    typedef struct packed {
        logic             start;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] prod;
    } mul_rsp_t;

endpackage

/* hw/rtl/asw_item_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asw_item_if
// input item channel: load, season start and week advance commands
// ----------------------------------------------------------------------------
interface asw_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [2:0]  row_index;
    logic [2:0]  col_index;
    logic [31:0] load_value;

    modport source (output valid, output mode, output row_index, output col_index,
                    output load_value, input ready);
    modport sink   (input valid, input mode, input row_index, input col_index,
                    input load_value, output ready);
endinterface

/* hw/rtl/asw_result_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asw_result_if
// result item channel: one item per age group after each week
// ----------------------------------------------------------------------------
interface asw_result_if;
    logic               valid;
    logic               ready;
    logic [2:0]         age_group;
    logic [15:0]        week_index;
    logic [30:0]        weekly_incidence;
    logic signed [31:0] attack_rate;
    logic               last_group;

    modport source (output valid, output age_group, output week_index,
                    output weekly_incidence, output attack_rate, output last_group,
                    input ready);
    modport sink   (input valid, input age_group, input week_index,
                    input weekly_incidence, input attack_rate, input last_group,
                    output ready);
endinterface

/* hw/rtl/asw_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asw_cfg_if
// configuration register write channel
// ----------------------------------------------------------------------------
interface asw_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/asw_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asw_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module asw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/asw_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asw_mul
// shared 64x64 multiplier built from 32x32 partial products, one per step
// ----------------------------------------------------------------------------
module asw_mul
    import asw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    typedef enum logic [2:0] {
        M_IDLE = 3'b001,
        M_MUL  = 3'b010,
        M_ACC  = 3'b100
    } mstate_t;

    mstate_t           state_reg, state_next;
    logic [MUL_W-1:0]  a_reg, b_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [63:0]       pp_reg;
    logic [3:0]        mask_reg;
    logic [1:0]        k_reg;
    logic              done_reg;
    logic [3:0]        need;
    logic [1:0]        k_low;
    logic [3:0]        mask_left;
    logic [31:0]       a_half, b_half;
    logic [PROD_W-1:0] pp_shifted;

    // partial k: bit 0 selects the upper half of b, bit 1 the upper half of a
    always_comb
    begin
        need[0] = (|req.a[31:0])  && (|req.b[31:0]);
        need[1] = (|req.a[31:0])  && (|req.b[63:32]);
        need[2] = (|req.a[63:32]) && (|req.b[31:0]);
        need[3] = (|req.a[63:32]) && (|req.b[63:32]);
    end

    always_comb
    begin
        if (mask_reg[0])
            k_low = 2'd0;
        else if (mask_reg[1])
            k_low = 2'd1;
        else if (mask_reg[2])
            k_low = 2'd2;
        else
            k_low = 2'd3;
    end

    assign a_half = k_low[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_half = k_low[0] ? b_reg[63:32] : b_reg[31:0];

    always_comb
    begin
        mask_left = mask_reg;
        mask_left[k_reg] = 1'b0;
    end

    always_comb
    begin
        case (k_reg)
            2'd0:    pp_shifted = PROD_W'(pp_reg);
            2'd3:    pp_shifted = PROD_W'(pp_reg) << 64;
            default: pp_shifted = PROD_W'(pp_reg) << 32;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            M_IDLE:
            begin
                if (req.start && (|need))
                    state_next = M_MUL;
            end
            M_MUL:   state_next = M_ACC;
            M_ACC:   state_next = (|mask_left) ? M_MUL : M_IDLE;
            default: state_next = M_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
            mask_reg  <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            case (state_reg)
                M_IDLE:
                begin
                    if (req.start)
                    begin
                        mask_reg <= need;
                        done_reg <= ~(|need);
                    end
                end
                M_ACC:
                begin
                    mask_reg <= mask_left;
                    done_reg <= ~(|mask_left);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            M_IDLE:
            begin
                if (req.start)
                begin
                    a_reg   <= req.a;
                    b_reg   <= req.b;
                    acc_reg <= '0;
                end
            end
            M_MUL:
            begin
                pp_reg <= a_half * b_half;
                k_reg  <= k_low;
            end
            M_ACC:   acc_reg <= acc_reg + pp_shifted;
            default: ;
        endcase
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

/* hw/rtl/age_structured_sir_week_stepper.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// age_structured_sir_week_stepper
// load and season start items return no result. a week item holds ready low
// until all G result items are taken: each product on the shared multiplier
// runs one multiply and one accumulate step per nonzero 32x32 partial product.
// not ready while a week runs. reset clears state and loads register defaults.
// ----------------------------------------------------------------------------
module age_structured_sir_week_stepper
    import asw_pkg::*;
#(
    parameter int AGE_GROUPS = 8
) (
    input  logic clk,
    input  logic rst_n,
    asw_item_if.sink     item,
    asw_result_if.source result,
    asw_cfg_if.sink      cfg
);

    localparam int IDX_W  = (AGE_GROUPS > 1) ? $clog2(AGE_GROUPS) : 1;
    localparam int KDEPTH = AGE_GROUPS * AGE_GROUPS;
    localparam int ADDR_W = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
    localparam int SW     = 45;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(AGE_GROUPS - 1);

    typedef enum logic [14:0] {
        S_IDLE      = 15'h0001,
        S_BETA      = 15'h0002,
        S_BETA_WAIT = 15'h0004,
        S_DAY       = 15'h0008,
        S_P_ISSUE   = 15'h0010,
        S_P_WAIT    = 15'h0020,
        S_K_ADDR    = 15'h0040,
        S_K_ISSUE   = 15'h0080,
        S_K_WAIT    = 15'h0100,
        S_L_ISSUE   = 15'h0200,
        S_L_WAIT    = 15'h0400,
        S_U_ISSUE   = 15'h0800,
        S_U_WAIT    = 15'h1000,
        S_U_WB      = 15'h2000,
        S_OUT       = 15'h4000
    } state_t;

    typedef enum logic [2:0] {
        US_NU = 3'd0,
        US_EL = 3'd1,
        US_NV = 3'd2,
        US_GU = 3'd3,
        US_GV = 3'd4,
        US_WN = 3'd5,
        US_PM = 3'd6
    } ustep_t;

    state_t state_reg, state_next;
    ustep_t ustep_reg;

    // configuration registers
    logic [31:0] r0_reg;
    logic [30:0] gamma_reg, ve_inf_reg, ve_spread_reg, ve_ill_reg;
    logic [15:0] pulse_day_reg;
    logic [30:0] init_s_reg, init_i_reg;

    // model state
    logic [30:0] su_reg [AGE_GROUPS];
    logic [30:0] iu_reg [AGE_GROUPS];
    logic [30:0] sv_reg [AGE_GROUPS];
    logic [30:0] iv_reg [AGE_GROUPS];
    logic [31:0] cc_reg [AGE_GROUPS];
    logic [31:0] pres_reg [AGE_GROUPS];
    logic [31:0] vf_reg [AGE_GROUPS];
    logic [31:0] p_reg [AGE_GROUPS];
    logic [KDEPTH-1:0] kvalid_reg;
    logic        kv_rd_reg;
    logic [15:0] week_reg;

    // sequencer
    logic [IDX_W-1:0] a_reg, j_reg;
    logic [2:0]  d_reg;
    logic        pulse_reg;
    logic [34:0] beta_reg;
    logic [42:0] acc_reg;
    logic [33:0] nu_reg, nv_reg, wn_reg;
    logic [31:0] el_reg, gu_reg, gv_reg;
    logic [40:0] mag_reg;

    mul_req_t mul_req;
    mul_rsp_t mul_rsp;

    logic [30:0] e_c, s_c, w_c;
    logic        item_acc, out_acc, row_ok, col_ok;
    logic [ADDR_W-1:0] k_waddr, k_raddr;
    logic        k_we;
    logic [31:0] k_rdata;
    logic [18:0] day_num;
    logic [30:0] su_a, iu_a, sv_a, iv_a;
    logic signed [SW-1:0] nsu_raw, nsv_raw, niu_raw, niv_raw, moved, abs_nsu;
    logic [35:0] nc_sum;
    logic signed [33:0] att;

    function automatic logic [30:0] effc(input logic [30:0] eff);
        effc = Q30_ONE - ((eff > Q30_ONE) ? Q30_ONE : eff);
    endfunction

    function automatic logic [30:0] clamp_unit(input logic signed [SW-1:0] v);
        if (v < 0)
            clamp_unit = '0;
        else if (v > signed'(SW'(Q30_ONE)))
            clamp_unit = Q30_ONE;
        else
            clamp_unit = v[30:0];
    endfunction

    assign e_c = effc(ve_inf_reg);
    assign s_c = effc(ve_spread_reg);
    assign w_c = effc(ve_ill_reg);

    assign item.ready   = (state_reg == S_IDLE);
    assign cfg.ready    = 1'b1;
    assign item_acc     = item.valid && item.ready;
    assign out_acc      = result.valid && result.ready;
    assign row_ok       = int'(item.row_index) < AGE_GROUPS;
    assign col_ok       = int'(item.col_index) < AGE_GROUPS;

    assign k_we    = item_acc && (item.mode == MODE_LOAD_CONTACT) && row_ok && col_ok;
    assign k_waddr = ADDR_W'(int'(item.row_index) * AGE_GROUPS + int'(item.col_index));
    assign k_raddr = ADDR_W'(int'(a_reg) * AGE_GROUPS + int'(j_reg));

    asw_ram #(
        .WIDTH(32),
        .DEPTH(KDEPTH)
    ) u_contact_ram (
        .clk   (clk),
        .we    (k_we),
        .waddr (k_waddr),
        .wdata (item.load_value),
        .raddr (k_raddr),
        .rdata (k_rdata)
    );

    asw_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    // week * 7 + day, wide enough that it never wraps
    assign day_num = ({3'b000, week_reg} << 3) - {3'b000, week_reg} + 19'(d_reg);

    assign su_a = su_reg[a_reg];
    assign iu_a = iu_reg[a_reg];
    assign sv_a = sv_reg[a_reg];
    assign iv_a = iv_reg[a_reg];

    always_comb
    begin
        nsu_raw = signed'(SW'(su_a)) - signed'(SW'(nu_reg));
        nsv_raw = signed'(SW'(sv_a)) - signed'(SW'(nv_reg));
        niu_raw = signed'(SW'(iu_a)) + signed'(SW'(nu_reg)) - signed'(SW'(gu_reg));
        niv_raw = signed'(SW'(iv_a)) + signed'(SW'(nv_reg)) - signed'(SW'(gv_reg));
        abs_nsu = (nsu_raw < 0) ? -nsu_raw : nsu_raw;
        if (!pulse_reg)
            moved = '0;
        else if (nsu_raw < 0)
            moved = -signed'(SW'(mag_reg));
        else
            moved = signed'(SW'(mag_reg));
        nc_sum = 36'(cc_reg[a_reg]) + 36'(nu_reg) + 36'(wn_reg);
    end

    // operand selection for the shared multiplier
    always_comb
    begin
        mul_req.start = 1'b0;
        mul_req.a     = '0;
        mul_req.b     = '0;
        case (state_reg)
            S_BETA:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = MUL_W'(r0_reg);
                mul_req.b     = MUL_W'(gamma_reg);
            end
            S_P_ISSUE:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = MUL_W'(s_c);
                mul_req.b     = MUL_W'(iv_reg[j_reg]);
            end
            S_K_ISSUE:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = kv_rd_reg ? MUL_W'(k_rdata) : '0;
                mul_req.b     = MUL_W'(p_reg[j_reg]);
            end
            S_L_ISSUE:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = MUL_W'(beta_reg);
                mul_req.b     = MUL_W'(acc_reg);
            end
            S_U_ISSUE:
            begin
                mul_req.start = 1'b1;
                case (ustep_reg)
                    US_NU:
                    begin
                        mul_req.a = MUL_W'(pres_reg[a_reg]);
                        mul_req.b = MUL_W'(su_a);
                    end
                    US_EL:
                    begin
                        mul_req.a = MUL_W'(e_c);
                        mul_req.b = MUL_W'(pres_reg[a_reg]);
                    end
                    US_NV:
                    begin
                        mul_req.a = MUL_W'(el_reg);
                        mul_req.b = MUL_W'(sv_a);
                    end
                    US_GU:
                    begin
                        mul_req.a = MUL_W'(gamma_reg);
                        mul_req.b = MUL_W'(iu_a);
                    end
                    US_GV:
                    begin
                        mul_req.a = MUL_W'(gamma_reg);
                        mul_req.b = MUL_W'(iv_a);
                    end
                    US_WN:
                    begin
                        mul_req.a = MUL_W'(w_c);
                        mul_req.b = MUL_W'(nv_reg);
                    end
                    default:
                    begin
                        mul_req.a = MUL_W'(vf_reg[a_reg]);
                        mul_req.b = MUL_W'(abs_nsu[33:0]);
                    end
                endcase
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_acc && (item.mode == MODE_ADVANCE_WEEK))
                    state_next = S_BETA;
            end
            S_BETA:      state_next = S_BETA_WAIT;
            S_BETA_WAIT: state_next = mul_rsp.done ? S_DAY : S_BETA_WAIT;
            S_DAY:       state_next = S_P_ISSUE;
            S_P_ISSUE:   state_next = S_P_WAIT;
            S_P_WAIT:
            begin
                if (mul_rsp.done)
                    state_next = (j_reg == LAST_IDX) ? S_K_ADDR : S_P_ISSUE;
            end
            S_K_ADDR:    state_next = S_K_ISSUE;
            S_K_ISSUE:   state_next = S_K_WAIT;
            S_K_WAIT:
            begin
                if (mul_rsp.done)
                    state_next = (j_reg == LAST_IDX) ? S_L_ISSUE : S_K_ADDR;
            end
            S_L_ISSUE:   state_next = S_L_WAIT;
            S_L_WAIT:
            begin
                if (mul_rsp.done)
                    state_next = (a_reg == LAST_IDX) ? S_U_ISSUE : S_K_ADDR;
            end
            S_U_ISSUE:   state_next = S_U_WAIT;
            S_U_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    if (ustep_reg == US_PM || (ustep_reg == US_WN && !pulse_reg))
                        state_next = S_U_WB;
                    else
                        state_next = S_U_ISSUE;
                end
            end
            S_U_WB:
            begin
                if (a_reg != LAST_IDX)
                    state_next = S_U_ISSUE;
                else if (d_reg == DAYS_PER_WEEK)
                    state_next = S_OUT;
                else
                    state_next = S_DAY;
            end
            S_OUT:
            begin
                if (out_acc && (a_reg == LAST_IDX))
                    state_next = S_IDLE;
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r0_reg        <= 32'd402653184;
            gamma_reg     <= 31'd357913941;
            ve_inf_reg    <= '0;
            ve_spread_reg <= '0;
            ve_ill_reg    <= '0;
            pulse_day_reg <= '0;
            init_s_reg    <= Q30_ONE;
            init_i_reg    <= 31'd10737;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_R0:        r0_reg        <= cfg.data;
                REG_RECOVERY:  gamma_reg     <= cfg.data[30:0];
                REG_VE_INF:    ve_inf_reg    <= cfg.data[30:0];
                REG_VE_SPREAD: ve_spread_reg <= cfg.data[30:0];
                REG_VE_ILL:    ve_ill_reg    <= cfg.data[30:0];
                REG_PULSE_DAY: pulse_day_reg <= cfg.data[15:0];
                REG_INIT_S:    init_s_reg    <= cfg.data[30:0];
                REG_INIT_I:    init_i_reg    <= cfg.data[30:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ustep_reg  <= US_NU;
            kvalid_reg <= '0;
            week_reg   <= '0;
            a_reg      <= '0;
            j_reg      <= '0;
            d_reg      <= 3'd1;
            pulse_reg  <= 1'b0;
            for (int i = 0; i < AGE_GROUPS; i++)
            begin
                su_reg[i]   <= '0;
                iu_reg[i]   <= '0;
                sv_reg[i]   <= '0;
                iv_reg[i]   <= '0;
                cc_reg[i]   <= '0;
                pres_reg[i] <= '0;
                vf_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (k_we)
                kvalid_reg[k_waddr] <= 1'b1;
            case (state_reg)
                S_IDLE:
                begin
                    if (item_acc)
                    begin
                        case (item.mode)
                            MODE_LOAD_VACC:
                            begin
                                if (row_ok)
                                    vf_reg[IDX_W'(item.row_index)] <= item.load_value;
                            end
                            MODE_START_SEASON:
                            begin
                                for (int i = 0; i < AGE_GROUPS; i++)
                                begin
                                    su_reg[i]   <= init_s_reg;
                                    iu_reg[i]   <= init_i_reg;
                                    sv_reg[i]   <= '0;
                                    iv_reg[i]   <= '0;
                                    cc_reg[i]   <= '0;
                                    pres_reg[i] <= '0;
                                end
                                week_reg <= '0;
                            end
                            MODE_ADVANCE_WEEK:
                            begin
                                for (int i = 0; i < AGE_GROUPS; i++)
                                    cc_reg[i] <= '0;
                                d_reg <= 3'd1;
                            end
                            default: ;
                        endcase
                    end
                end
                S_DAY:
                begin
                    pulse_reg <= (pulse_day_reg != 16'd0) && (day_num == 19'(pulse_day_reg));
                    j_reg     <= '0;
                end
                S_P_WAIT:
                begin
                    if (mul_rsp.done)
                    begin
                        j_reg <= (j_reg == LAST_IDX) ? '0 : j_reg + 1'b1;
                        a_reg <= '0;
                    end
                end
                S_K_WAIT:
                begin
                    if (mul_rsp.done && (j_reg != LAST_IDX))
                        j_reg <= j_reg + 1'b1;
                end
                S_L_WAIT:
                begin
                    if (mul_rsp.done)
                    begin
                        // lambda saturates at 32 bits
                        pres_reg[a_reg] <= (|mul_rsp.prod[PROD_W-1:62]) ? SAT32
                                                                         : mul_rsp.prod[61:30];
                        j_reg     <= '0;
                        a_reg     <= (a_reg == LAST_IDX) ? '0 : a_reg + 1'b1;
                        ustep_reg <= US_NU;
                    end
                end
                S_U_WAIT:
                begin
                    if (mul_rsp.done && ustep_reg != US_PM)
                        ustep_reg <= ustep_t'(ustep_reg + 3'd1);
                end
                S_U_WB:
                begin
                    su_reg[a_reg] <= clamp_unit(nsu_raw - moved);
                    sv_reg[a_reg] <= clamp_unit(nsv_raw + moved);
                    iu_reg[a_reg] <= clamp_unit(niu_raw);
                    iv_reg[a_reg] <= clamp_unit(niv_raw);
                    cc_reg[a_reg] <= (|nc_sum[35:32]) ? SAT32 : nc_sum[31:0];
                    ustep_reg     <= US_NU;
                    if (a_reg != LAST_IDX)
                        a_reg <= a_reg + 1'b1;
                    else
                    begin
                        a_reg <= '0;
                        if (d_reg != DAYS_PER_WEEK)
                            d_reg <= d_reg + 3'd1;
                    end
                end
                S_OUT:
                begin
                    if (out_acc)
                    begin
                        if (a_reg == LAST_IDX)
                        begin
                            a_reg    <= '0;
                            week_reg <= week_reg + 16'd1;
                        end
                        else
                            a_reg <= a_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath holding registers
    always_ff @(posedge clk)
    begin
        kv_rd_reg <= kvalid_reg[k_raddr];
        case (state_reg)
            S_BETA_WAIT:
            begin
                if (mul_rsp.done)
                    beta_reg <= mul_rsp.prod[62:28];
            end
            S_P_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    p_reg[j_reg] <= {1'b0, iu_reg[j_reg]} + mul_rsp.prod[61:30];
                    acc_reg      <= '0;
                end
            end
            S_K_WAIT:
            begin
                if (mul_rsp.done)
                    acc_reg <= acc_reg + 43'(mul_rsp.prod[63:24]);
            end
            S_L_WAIT:
            begin
                if (mul_rsp.done)
                    acc_reg <= '0;
            end
            S_U_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    case (ustep_reg)
                        US_NU:   nu_reg <= mul_rsp.prod[63:30];
                        US_EL:   el_reg <= mul_rsp.prod[61:30];
                        US_NV:   nv_reg <= mul_rsp.prod[63:30];
                        US_GU:   gu_reg <= mul_rsp.prod[61:30];
                        US_GV:   gv_reg <= mul_rsp.prod[61:30];
                        US_WN:   wn_reg <= mul_rsp.prod[63:30];
                        // a transfer product beyond 64 bits takes the fixed cap
                        default: mag_reg <= (|mul_rsp.prod[PROD_W-1:64]) ? MOVE_CAP
                                                                         : 41'(mul_rsp.prod[63:30]);
                    endcase
                end
            end
            default: ;
        endcase
    end

    // result fields come straight from held state while the week output runs
    assign att = signed'(34'(init_s_reg)) - signed'(34'(su_a)) - signed'(34'(sv_a));

    assign result.valid            = (state_reg == S_OUT);
    assign result.age_group        = 3'(a_reg);
    assign result.week_index       = week_reg;
    assign result.weekly_incidence = cc_reg[a_reg][31] ? 31'h7FFF_FFFF : cc_reg[a_reg][30:0];
    assign result.attack_rate      = (att < -34'sd2147483648) ? 32'sh8000_0000 : att[31:0];
    assign result.last_group       = (a_reg == LAST_IDX);

endmodule

/* sim/age_structured_sir_week_stepper_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// age_structured_sir_week_stepper_test
// Drives load, season and week items through the stepper under random
// handshake gaps, rewrites every configuration register between phases,
// and checks every per-age result against a fixed-point epidemic predictor.
// ----------------------------------------------------------------------------
module age_structured_sir_week_stepper_test
    import asw_pkg::*;
();

    localparam int GROUPS = 8;
    localparam int CYCLE_LIMIT = 20000000;
    localparam logic [63:0] ONE_Q30 = 64'h4000_0000;
    localparam logic [63:0] CAP64 = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [2:0]  age_group;
        logic [15:0] week_index;
        logic [30:0] weekly_incidence;
        logic [31:0] attack_rate;
        logic        last_group;
    } week_result_t;

    typedef struct packed {
        mode_t       mode;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] value;
        logic        typed;
        logic [30:0] incidence;
        logic [31:0] attack;
    } stim_row_t;

    logic clk;
    logic rst_n;
    int   cycles;
    int   errors;

    asw_item_if   item_ch();
    asw_result_if result_ch();
    asw_cfg_if    cfg_ch();

    age_structured_sir_week_stepper #(.AGE_GROUPS(GROUPS)) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // epidemic state as the block should hold it
    logic [31:0] sus_u[GROUPS], inf_u[GROUPS], sus_v[GROUPS], inf_v[GROUPS];
    logic [31:0] counted[GROUPS], pressure[GROUPS], vacc_frac[GROUPS];
    logic [31:0] contacts[GROUPS*GROUPS];
    logic [15:0] season_week;
    logic [31:0] r0_q, gamma_q, ve_inf_q, ve_spread_q, ve_ill_q, init_s_q, init_i_q;
    logic [15:0] pulse_q;

    week_result_t pending_results[$];
    stim_row_t    directed_rows[12];

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = 1'b1;
            #2 clk = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // truncating product with a ceiling, overflow of 64 bits gives the ceiling
    function automatic logic [63:0] scaled_product(input logic [63:0] a, input logic [63:0] b,
                                                   input int sh, input logic [63:0] cap);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        if (p[127:64] != 0)
            return cap;
        p = p >> sh;
        if (p[63:0] > cap)
            return cap;
        return p[63:0];
    endfunction

    function automatic logic [63:0] efficacy_complement(input logic [31:0] eff);
        return ONE_Q30 - (({32'd0, eff} > ONE_Q30) ? ONE_Q30 : {32'd0, eff});
    endfunction

    function automatic logic [31:0] clamp_fraction(input logic signed [63:0] v);
        if (v < 0)
            return 32'd0;
        if (v > $signed(ONE_Q30))
            return ONE_Q30[31:0];
        return v[31:0];
    endfunction

    task automatic euler_day(input logic [63:0] beta, input logic pulse);
        logic [63:0] s, e, w, acc, lam, nu, nv, nc, mag, absv;
        logic signed [63:0] nsu, niu, nsv, niv, moved;
        s = efficacy_complement(ve_spread_q);
        e = efficacy_complement(ve_inf_q);
        w = efficacy_complement(ve_ill_q);
        for (int a = 0; a < GROUPS; a++)
        begin
            acc = 0;
            for (int j = 0; j < GROUPS; j++)
                acc = acc + scaled_product(contacts[a*GROUPS+j],
                      {32'd0, inf_u[j]} + scaled_product(s, inf_v[j], 30, CAP64), 24, CAP64);
            pressure[a] = 32'(scaled_product(beta, acc, 30, {32'd0, SAT32}));
        end
        for (int a = 0; a < GROUPS; a++)
        begin
            lam = pressure[a];
            nu = scaled_product(lam, sus_u[a], 30, CAP64);
            nv = scaled_product(scaled_product(e, lam, 30, CAP64), sus_v[a], 30, CAP64);
            nsu = {32'd0, sus_u[a]} - nu;
            niu = {32'd0, inf_u[a]} + nu - scaled_product(gamma_q, inf_u[a], 30, CAP64);
            nsv = {32'd0, sus_v[a]} - nv;
            niv = {32'd0, inf_v[a]} + nv - scaled_product(gamma_q, inf_v[a], 30, CAP64);
            nc = {32'd0, counted[a]} + nu + scaled_product(w, nv, 30, CAP64);
            if (pulse)
            begin
                absv = (nsu < 0) ? -nsu : nsu;
                mag = scaled_product(vacc_frac[a], absv, 30, {23'd0, MOVE_CAP});
                moved = (nsu < 0) ? -mag : mag;
                nsu = nsu - moved;
                nsv = nsv + moved;
            end
            sus_u[a] = clamp_fraction(nsu);
            inf_u[a] = clamp_fraction(niu);
            sus_v[a] = clamp_fraction(nsv);
            inf_v[a] = clamp_fraction(niv);
            counted[a] = (nc > {32'd0, SAT32}) ? SAT32 : nc[31:0];
        end
    endtask

    // advances the predicted state by one accepted item and queues its results
    task automatic predict_item(input stim_row_t r);
        logic [63:0] beta;
        logic [31:0] day;
        logic signed [63:0] att;
        week_result_t res;
        case (r.mode)
            MODE_LOAD_CONTACT: contacts[r.row*GROUPS+r.col] = r.value;
            MODE_LOAD_VACC:    vacc_frac[r.row] = r.value;
            MODE_START_SEASON:
            begin
                for (int a = 0; a < GROUPS; a++)
                begin
                    sus_u[a] = init_s_q;
                    inf_u[a] = init_i_q;
                    sus_v[a] = 0;
                    inf_v[a] = 0;
                    counted[a] = 0;
                    pressure[a] = 0;
                end
                season_week = 0;
            end
            default:
            begin
                beta = ({32'd0, r0_q} * {32'd0, gamma_q}) >> 28;
                for (int a = 0; a < GROUPS; a++)
                    counted[a] = 0;
                for (int d = 1; d <= 7; d++)
                begin
                    day = season_week * 7 + d;
                    euler_day(beta, pulse_q != 0 && day == {16'd0, pulse_q});
                end
                for (int a = 0; a < GROUPS; a++)
                begin
                    att = $signed({32'd0, init_s_q}) - $signed({32'd0, sus_u[a]})
                          - $signed({32'd0, sus_v[a]});
                    if (att > 64'sd2147483647)
                        att = 64'sd2147483647;
                    if (att < -64'sd2147483648)
                        att = -64'sd2147483648;
                    res.age_group = 3'(a);
                    res.week_index = season_week;
                    res.weekly_incidence = (counted[a] > 32'h7FFF_FFFF) ? 31'h7FFF_FFFF
                                                                      : counted[a][30:0];
                    res.attack_rate = att[31:0];
                    res.last_group = (a == GROUPS - 1);
                    if (r.typed)
                    begin
                        res.weekly_incidence = r.incidence;
                        res.attack_rate = r.attack;
                    end
                    pending_results = {pending_results, res};
                end
                season_week = season_week + 1;
            end
        endcase
    endtask

    task automatic send_item(input stim_row_t r);
        int gap;
        @(negedge clk);
        item_ch.valid      <= 1'b1;
        item_ch.mode       <= r.mode;
        item_ch.row_index  <= r.row;
        item_ch.col_index  <= r.col;
        item_ch.load_value <= r.value;
        do
            @(posedge clk);
        while (!item_ch.ready);
        predict_item(r);
        gap = ($urandom_range(0, 9) < 6) ? 0 :
              ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0)
        begin
            @(negedge clk);
            item_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [31:0] data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            REG_R0:        r0_q = data;
            REG_RECOVERY:  gamma_q = {1'b0, data[30:0]};
            REG_VE_INF:    ve_inf_q = {1'b0, data[30:0]};
            REG_VE_SPREAD: ve_spread_q = {1'b0, data[30:0]};
            REG_VE_ILL:    ve_ill_q = {1'b0, data[30:0]};
            REG_PULSE_DAY: pulse_q = data[15:0];
            REG_INIT_S:    init_s_q = {1'b0, data[30:0]};
            default:       init_i_q = {1'b0, data[30:0]};
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_fraction();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return $urandom;
            2:       return 32'h4000_0000;
            default: return $urandom_range(0, 32'h4000_0000);
        endcase
    endfunction

    function automatic stim_row_t random_row(input mode_t m);
        stim_row_t r;
        r = '0;
        r.mode = m;
        r.row = 3'($urandom_range(0, 7));
        r.col = 3'($urandom_range(0, 7));
        if (m == MODE_LOAD_CONTACT)
            r.value = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 32'h0200_0000);
        else if (m == MODE_LOAD_VACC)
            r.value = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 32'h4000_0000);
        else
            r.value = $urandom;
        return r;
    endfunction

    // result side: random stalls, mostly short
    int stall_left;
    always @(negedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            result_ch.ready <= 1'b0;
        end
        else if ($urandom_range(0, 9) < 3)
        begin
            stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
                                                     : $urandom_range(15, 60);
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        week_result_t want;
        if (result_ch.valid && result_ch.ready)
        begin
            if (pending_results.size() == 0)
                report("unexpected item", result_ch.age_group, 0);
            else
            begin
                want = pending_results.pop_front();
                if (result_ch.age_group !== want.age_group)
                    report("age_group", result_ch.age_group, want.age_group);
                if (result_ch.week_index !== want.week_index)
                    report("week_index", result_ch.week_index, want.week_index);
                if (result_ch.weekly_incidence !== want.weekly_incidence)
                    report("weekly_incidence", result_ch.weekly_incidence,
                           want.weekly_incidence);
                if (result_ch.attack_rate !== want.attack_rate)
                    report("attack_rate", result_ch.attack_rate, want.attack_rate);
                if (result_ch.last_group !== want.last_group)
                    report("last_group", result_ch.last_group, want.last_group);
            end
        end
    end

    initial
    begin
        int sent;
        int nloads;
        int nweeks;
        stim_row_t r;

        cycles = 0;
        errors = 0;
        stall_left = 0;
        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.mode = MODE_LOAD_CONTACT;
        item_ch.row_index = 0;
        item_ch.col_index = 0;
        item_ch.load_value = 0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_R0;
        cfg_ch.data = 0;
        result_ch.ready = 1'b0;

        for (int a = 0; a < GROUPS; a++)
        begin
            sus_u[a] = 0; inf_u[a] = 0; sus_v[a] = 0; inf_v[a] = 0;
            counted[a] = 0; pressure[a] = 0; vacc_frac[a] = 0;
        end
        for (int k = 0; k < GROUPS*GROUPS; k++)
            contacts[k] = 0;
        season_week = 0;
        r0_q = 32'd402653184;
        gamma_q = 32'd357913941;
        ve_inf_q = 0; ve_spread_q = 0; ve_ill_q = 0;
        pulse_q = 0;
        init_s_q = 32'h4000_0000;
        init_i_q = 32'd10737;

        // weeks before any season run on the zero state: nothing counted,
        // attack rate equals the full initial susceptible fraction
        directed_rows = '{
            '{MODE_ADVANCE_WEEK, 3'd0, 3'd0, 32'h0, 1'b1, 31'd0, 32'h4000_0000},
            '{MODE_ADVANCE_WEEK, 3'd7, 3'd7, 32'hFFFF_FFFF, 1'b1, 31'd0, 32'h4000_0000},
            '{MODE_LOAD_CONTACT, 3'd7, 3'd7, 32'hFFFF_FFFF, 1'b0, 31'd0, 32'h0},
            '{MODE_LOAD_CONTACT, 3'd0, 3'd0, 32'h0, 1'b0, 31'd0, 32'h0},
            '{MODE_LOAD_CONTACT, 3'd3, 3'd5, 32'h0100_0000, 1'b0, 31'd0, 32'h0},
            '{MODE_LOAD_VACC, 3'd7, 3'd0, 32'hFFFF_FFFF, 1'b0, 31'd0, 32'h0},
            '{MODE_LOAD_VACC, 3'd0, 3'd7, 32'h0, 1'b0, 31'd0, 32'h0},
            '{MODE_LOAD_VACC, 3'd2, 3'd1, 32'h2000_0000, 1'b0, 31'd0, 32'h0},
            '{MODE_START_SEASON, 3'd5, 3'd2, 32'hA5A5_5A5A, 1'b0, 31'd0, 32'h0},
            '{MODE_ADVANCE_WEEK, 3'd0, 3'd0, 32'h0, 1'b0, 31'd0, 32'h0},
            '{MODE_ADVANCE_WEEK, 3'd0, 3'd0, 32'h0, 1'b0, 31'd0, 32'h0},
            '{MODE_START_SEASON, 3'd0, 3'd0, 32'h0, 1'b0, 31'd0, 32'h0}
        };

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i]);
        sent = 12;

        for (int phase = 0; phase < 6; phase++)
        begin
            // sender holds off until every result is back before reconfiguring
            wait_drained();
            case (phase)
                0:
                begin
                    write_register(REG_R0, 32'hFFFF_FFFF);
                    write_register(REG_RECOVERY, 32'h7FFF_FFFF);
                    write_register(REG_VE_INF, 32'h7FFF_FFFF);
                    write_register(REG_VE_SPREAD, 32'h4000_0000);
                    write_register(REG_VE_ILL, 32'h7FFF_FFFF);
                    write_register(REG_PULSE_DAY, 32'd3);
                    write_register(REG_INIT_S, 32'h7FFF_FFFF);
                    write_register(REG_INIT_I, 32'h7FFF_FFFF);
                end
                1:
                begin
                    write_register(REG_R0, 32'd0);
                    write_register(REG_RECOVERY, 32'd0);
                    write_register(REG_VE_INF, 32'd0);
                    write_register(REG_VE_SPREAD, 32'd0);
                    write_register(REG_VE_ILL, 32'd0);
                    write_register(REG_PULSE_DAY, 32'hFFFF_FFFF);
                    write_register(REG_INIT_S, 32'd0);
                    write_register(REG_INIT_I, 32'd0);
                end
                default:
                begin
                    write_register(REG_R0, ($urandom_range(0, 3) == 0) ? $urandom
                                           : $urandom_range(32'h0800_0000, 32'h4000_0000));
                    write_register(REG_RECOVERY, ($urandom_range(0, 4) == 0) ? $urandom
                                           : $urandom_range(32'h0200_0000, 32'h2000_0000));
                    write_register(REG_VE_INF, pick_fraction());
                    write_register(REG_VE_SPREAD, pick_fraction());
                    write_register(REG_VE_ILL, pick_fraction());
                    write_register(REG_PULSE_DAY, ($urandom_range(0, 3) == 0) ? $urandom
                                           : {16'($urandom_range(0, 65535)), 16'(
                                              $urandom_range(0, 20))});
                    write_register(REG_INIT_S, pick_fraction());
                    write_register(REG_INIT_I, ($urandom_range(0, 3) == 0) ? pick_fraction()
                                           : $urandom_range(0, 32'h0010_0000));
                end
            endcase

            while (sent < 12 + 76 * (phase + 1))
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    // well-formed season: loads, start, a few weeks
                    nloads = $urandom_range(0, 5);
                    for (int k = 0; k < nloads; k++)
                        send_item(random_row($urandom_range(0, 1) ? MODE_LOAD_CONTACT
                                                                  : MODE_LOAD_VACC));
                    send_item(random_row(MODE_START_SEASON));
                    nweeks = $urandom_range(1, 4);
                    for (int k = 0; k < nweeks; k++)
                        send_item(random_row(MODE_ADVANCE_WEEK));
                    sent += nloads + 1 + nweeks;
                end
                else
                begin
                    r = random_row(mode_t'($urandom_range(0, 3)));
                    send_item(r);
                    sent++;
                end
            end
        end

        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
